>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// shared codes, widths and the character lookup of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SextetW = 6;
  localparam int unsigned GroupW  = 3 * SextetW;
  localparam int unsigned WordW   = 4 * SextetW;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [ByteW-1:0] PadSym = 8'd64;
  localparam logic [ByteW-1:0] BadSym = 8'd255;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_BADCHAR  = 3'd3,
    ST_SHORT    = 3'd4,
    ST_PADMIS   = 3'd5
  } status_e;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_e;

  typedef enum logic {
    REG_URL_MODE = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_e;

  // sextet value, PadSym for '=' in standard mode, BadSym otherwise
  function automatic logic [ByteW-1:0] sextet_of(input logic [ByteW-1:0] c,
                                                  input logic url);
    logic [ByteW-1:0] v;
    v = BadSym;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (url) begin
      if (c == 8'h2d) v = 8'd62;
      else if (c == 8'h5f) v = 8'd63;
    end else begin
      if (c == 8'h2b) v = 8'd62;
      else if (c == 8'h2f) v = 8'd63;
      else if (c == 8'h3d) v = PadSym;
    end
    return v;
  endfunction

endpackage

>>> rtl/b64d_if.sv
// ----------------------------------------------------------------------------
// b64d stream interfaces
// valid/ready channels for character items and decoded result items
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  data_byte;
  logic        last;
  logic [2:0]  status;
  logic [15:0] byte_count;

  modport source (output valid, output has_byte, output data_byte, output last,
                  output status, output byte_count, input ready);
  modport sink   (input valid, input has_byte, input data_byte, input last,
                  input status, input byte_count, output ready);
endinterface

>>> rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// a result is registered and appears in the cycle after its item is accepted
// throughput: one item per cycle while each item gives at most one result and
//   results are taken at once; else the next item waits for the last result to go
// reset: group state, error latch and byte counter cleared, result buffer emptied;
//   url_mode resets to 0, out_capacity to 65535
// ----------------------------------------------------------------------------
module base64_stream_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  b64d_in_if.sink                      in_i,
  b64d_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [b64d_pkg::AddrW-1:0]   paddr,
  input  logic [b64d_pkg::DataW-1:0]   pwdata,
  output logic [b64d_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import b64d_pkg::*;

  // configuration
  logic              url_q;
  logic [CountW-1:0] cap_q;
  logic              cfg_wr;
  reg_e              cfg_sel;

  // decode state
  logic [GroupW-1:0] bits_q, bits_d;
  logic [1:0]        pos_q, pos_d;
  logic              pad_q, pad_d;
  status_e           err_q, err_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  // result buffer
  logic [WordW-1:0]  word_q, word_d;
  logic [1:0]        nb_q, nb_d;
  logic              close_q, close_d;
  status_e           cst_q, cst_d;
  logic [CountW-1:0] ccnt_q, ccnt_d;

  logic              in_fire, out_fire;
  logic [ByteW-1:0]  sym;
  logic [WordW-1:0]  emit_w;
  logic [1:0]        emit_n;
  logic [CountW:0]   cnt_sum;

  assign cfg_sel = reg_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign prdata  = (cfg_sel == REG_CAPACITY) ? {{(DataW-CountW){1'b0}}, cap_q}
                                             : {{(DataW-1){1'b0}}, url_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b0;
      cap_q <= {CountW{1'b1}};
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_URL_MODE: url_q <= pwdata[0];
        REG_CAPACITY: cap_q <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  assign out_o.valid      = (nb_q != 2'd0) | close_q;
  assign out_o.has_byte   = (nb_q != 2'd0);
  assign out_o.data_byte  = (nb_q != 2'd0) ? word_q[WordW-1 -: ByteW] : '0;
  assign out_o.last       = (nb_q == 2'd0) & close_q;
  assign out_o.status     = (nb_q != 2'd0) ? ST_OK : cst_q;
  assign out_o.byte_count = (nb_q != 2'd0) ? '0 : ccnt_q;

  assign in_i.ready = ((nb_q == 2'd0) & !close_q) |
                      (out_fire & (((nb_q == 2'd1) & !close_q) |
                                   ((nb_q == 2'd0) & close_q)));

  assign sym = sextet_of(in_i.char_code, url_q);

  always_comb begin
    bits_d  = bits_q;
    pos_d   = pos_q;
    pad_d   = pad_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    emit_w  = '0;
    emit_n  = 2'd0;
    cnt_sum = '0;
    word_d  = word_q;
    nb_d    = nb_q;
    close_d = close_q;
    cst_d   = cst_q;
    ccnt_d  = ccnt_q;

    if (out_fire) begin
      if (nb_q != 2'd0) begin
        nb_d   = nb_q - 2'd1;
        word_d = {word_q[WordW-ByteW-1:0], {ByteW{1'b0}}};
      end else begin
        close_d = 1'b0;
      end
    end

    if (in_fire) begin
      if (op_e'(in_i.op) == OP_END) begin
        if (err_q == ST_OK) begin
          if (!url_q) begin
            if (pos_q != 2'd0 || pad_q) err_d = ST_LENGTH;
          end else if (pos_q == 2'd1) begin
            err_d = ST_SHORT;
          end else if (pos_q == 2'd2) begin
            emit_w = {bits_q[11:0], 12'b0};
            emit_n = 2'd1;
          end else if (pos_q == 2'd3) begin
            emit_w = {bits_q, {SextetW{1'b0}}};
            emit_n = 2'd2;
          end
        end
      end else if (err_q == ST_OK) begin
        if (pad_q) begin
          if (sym != PadSym) begin
            err_d = ST_PADMIS;
          end else begin
            emit_w = {bits_q[11:0], 12'b0};
            emit_n = 2'd1;
            bits_d = '0;
            pos_d  = 2'd0;
            pad_d  = 1'b0;
          end
        end else if (sym == BadSym) begin
          err_d = ST_BADCHAR;
        end else if (sym == PadSym) begin
          if (pos_q < 2'd2) begin
            err_d = ST_SHORT;
          end else if (pos_q == 2'd2) begin
            pad_d = 1'b1;
            pos_d = 2'd3;
          end else begin
            emit_w = {bits_q, {SextetW{1'b0}}};
            emit_n = 2'd2;
            bits_d = '0;
            pos_d  = 2'd0;
          end
        end else if (pos_q != 2'd3) begin
          bits_d = {bits_q[GroupW-SextetW-1:0], sym[SextetW-1:0]};
          pos_d  = pos_q + 2'd1;
        end else begin
          emit_w = {bits_q, sym[SextetW-1:0]};
          emit_n = 2'd3;
          bits_d = '0;
          pos_d  = 2'd0;
        end
      end

      // capacity check on the group's bytes
      cnt_sum = {1'b0, cnt_q} + {{(CountW-1){1'b0}}, emit_n};
      nb_d    = 2'd0;
      word_d  = emit_w;
      if (emit_n != 2'd0) begin
        if (cnt_sum > {1'b0, cap_q}) begin
          err_d = ST_OVERFLOW;
        end else begin
          nb_d  = emit_n;
          cnt_d = cnt_sum[CountW-1:0];
        end
      end

      close_d = 1'b0;
      if (op_e'(in_i.op) == OP_END) begin
        close_d = 1'b1;
        cst_d   = err_d;
        ccnt_d  = cnt_d;
        bits_d  = '0;
        pos_d   = 2'd0;
        pad_d   = 1'b0;
        err_d   = ST_OK;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= '0;
      pos_q   <= 2'd0;
      pad_q   <= 1'b0;
      err_q   <= ST_OK;
      cnt_q   <= '0;
      nb_q    <= 2'd0;
      close_q <= 1'b0;
    end else begin
      bits_q  <= bits_d;
      pos_q   <= pos_d;
      pad_q   <= pad_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
      nb_q    <= nb_d;
      close_q <= close_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    cst_q  <= cst_d;
    ccnt_q <= ccnt_d;
  end

  // an end item always leaves a closing result behind
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.op == OP_END) |=> (close_q && out_o.valid))
    else $error("end item gave no closing result");

  // message state is cleared by an end item
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.op == OP_END) |=>
      (pos_q == 2'd0 && !pad_q && err_q == ST_OK && cnt_q == '0))
    else $error("message state not cleared after end item");

  // a latched error holds until the end item
  a_err_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK && !(in_fire && in_i.op == OP_END)) |=>
      (err_q == $past(err_q)))
    else $error("latched error changed within a message");

  // a new item is only taken when the buffer drains
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_o.valid) |-> (out_fire && (nb_q + {1'b0, close_q}) == 2'd1))
    else $error("item accepted over pending results");

endmodule
